// ===== rtl/dtw_pkg.sv =====
package dtw_pkg;

	localparam int WINDOW_DAYS_DEF = 15;

	localparam int KELVIN_W  = 15;
	localparam int CELSIUS_W = 16;
	localparam int TOTAL_W   = 20;
	localparam int DEFICIT_W = 22;
	localparam int TERM_W    = 45;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 22;

	localparam logic signed [CELSIUS_W-1:0] KELVIN_OFFSET = 16'sd17482;
	localparam logic [DEFICIT_W-1:0] DEFICIT_MAX = 22'd4194303;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_THRESHOLD = 8'd0,
		CFG_DEFICIT_FLOOR    = 8'd1
	} cfg_index_t;

	typedef struct packed {
		logic                start;
		logic [KELVIN_W-1:0] kelvin;
	} mag_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [TERM_W-1:0] term;
	} mag_rsp_t;

	typedef struct packed {
		logic signed [32:0] mul;
		logic [5:0]         sh;
	} recip_t;

	// Exact division by 1 to 6 for 32-bit dividends: multiply, then shift.
	function automatic recip_t recip(input logic [2:0] k);
		recip_t r;
		unique case (k)
			3'd2:    begin r.mul = 33'sd1;          r.sh = 6'd1;  end
			3'd3:    begin r.mul = 33'sd2863311531; r.sh = 6'd33; end
			3'd4:    begin r.mul = 33'sd1;          r.sh = 6'd2;  end
			3'd5:    begin r.mul = 33'sd3435973837; r.sh = 6'd34; end
			3'd6:    begin r.mul = 33'sd2863311531; r.sh = 6'd34; end
			default: begin r.mul = 33'sd1;          r.sh = 6'd0;  end
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/daily_temperature_window_and_vpd_core.sv =====
// Takes one day per input word (dewpoint, maximum and minimum temperature in kelvin with six
// fraction bits) and returns one word with the window flag, the saturated window sum of Celsius
// means, the daily mean, the clamped dewpoint and the vapor pressure deficit in 1/16 Pa. Two
// Magnus terms are evaluated one after the other on a single sequenced unit, each a 38-step
// restoring division followed by fifteen passes through one shared 33 by 33 bit multiplier.
// The input is not ready while a day is in work; a finished word waits in the output register
// while the next day is taken.
module daily_temperature_window_and_vpd_core #(
	parameter int WINDOW_DAYS = dtw_pkg::WINDOW_DAYS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // dewpoint_kelvin, max_kelvin, min_kelvin, zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // window_total, mean_kelvin, dewpoint_used, deficit
	output logic [0:0]  m_tuser,  // transpiring
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [dtw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dtw_pkg::CFG_DAT_W-1:0] cfg_data
);
	import dtw_pkg::*;

	localparam int HEAD_W = (WINDOW_DAYS > 1) ? $clog2(WINDOW_DAYS) : 1;
	localparam int DAYS_W = $clog2(WINDOW_DAYS + 1);
	localparam int SUM_W  = CELSIUS_W + DAYS_W;
	localparam int EXT_W  = (SUM_W > TOTAL_W + 1) ? SUM_W : TOTAL_W + 1;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_UPD  = 5'b00010,
		ST_MEAN = 5'b00100,
		ST_DEW  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t state_q;
	logic signed [CELSIUS_W-1:0] ring_q [WINDOW_DAYS];
	logic signed [CELSIUS_W-1:0] old_q;
	logic [HEAD_W-1:0] head_q;
	logic [DAYS_W-1:0] days_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [TOTAL_W-1:0] thresh_q;
	logic [DEFICIT_W-1:0] floor_q;
	logic [KELVIN_W-1:0] mean_q, dew_q;
	logic [TERM_W-1:0] em_q, ed_q;
	logic [TOTAL_W-1:0] total_o_q;
	logic [KELVIN_W-1:0] mean_o_q, dew_o_q;
	logic [DEFICIT_W-1:0] def_o_q;
	logic flag_o_q, m_valid_q;

	logic [KELVIN_W-1:0] in_dew, in_max, in_min, in_mean, dew_clamp;
	logic [KELVIN_W:0] in_add;
	logic signed [CELSIUS_W-1:0] cel;
	logic signed [SUM_W-1:0] sum_next;
	logic signed [EXT_W-1:0] sum_ext;
	logic signed [TOTAL_W-1:0] total;
	logic [TERM_W-1:0] diff;
	logic [DEFICIT_W-1:0] deficit;
	logic full, accept, out_free;
	mag_req_t mreq;
	mag_rsp_t mrsp;

	assign in_dew  = s_tdata[14:0];
	assign in_max  = s_tdata[29:15];
	assign in_min  = s_tdata[44:30];
	assign in_add  = {1'b0, in_max} + {1'b0, in_min};
	assign in_mean = in_add[KELVIN_W:1];

	always_comb begin
		if (in_dew >= in_mean) begin
			dew_clamp = (in_mean >= 15'd64) ? in_mean - 15'd64 : '0;
		end else if (in_min >= 15'd256 && in_dew < in_min - 15'd256) begin
			dew_clamp = in_min - 15'd256;
		end else begin
			dew_clamp = in_dew;
		end
	end

	assign full = days_q == DAYS_W'(WINDOW_DAYS);
	assign cel = $signed({1'b0, mean_q}) - KELVIN_OFFSET;
	assign sum_next = sum_q + SUM_W'(cel) - (full ? SUM_W'(old_q) : SUM_W'(0));
	assign sum_ext = EXT_W'(sum_q);

	always_comb begin
		if (sum_ext > EXT_W'(524287)) begin
			total = 20'sd524287;
		end else if (sum_ext < -EXT_W'(524288)) begin
			total = -20'sd524288;
		end else begin
			total = sum_ext[TOTAL_W-1:0];
		end
	end

	assign diff = (em_q > ed_q) ? em_q - ed_q : '0;
	always_comb begin
		if (diff[TERM_W-1:8] < (TERM_W-8)'(floor_q)) begin
			deficit = '0;
		end else if (diff[TERM_W-1:8] > (TERM_W-8)'(DEFICIT_MAX)) begin
			deficit = DEFICIT_MAX;
		end else begin
			deficit = diff[DEFICIT_W+7:8];
		end
	end

	assign s_tready = state_q == ST_IDLE;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign cfg_ready = 1'b1;

	always_comb begin
		mreq.start  = 1'b0;
		mreq.kelvin = mean_q;
		unique case (state_q)
			ST_UPD: mreq.start = 1'b1;
			ST_DEW: begin
				mreq.kelvin = dew_q;
				mreq.start  = !mrsp.busy;
			end
			default: begin
			end
		endcase
	end

	dtw_magnus u_magnus (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	always_ff @(posedge clk) begin
		old_q <= ring_q[head_q];
		if (state_q == ST_UPD) ring_q[head_q] <= cel;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mean_q <= in_mean;
			dew_q  <= dew_clamp;
		end
		if (state_q == ST_MEAN && mrsp.done) em_q <= mrsp.term;
		if (state_q == ST_DEW && mrsp.done) ed_q <= mrsp.term;
		if (state_q == ST_OUT && out_free) begin
			flag_o_q  <= total >= thresh_q;
			total_o_q <= total;
			mean_o_q  <= mean_q;
			dew_o_q   <= dew_q;
			def_o_q   <= deficit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			head_q    <= '0;
			days_q    <= '0;
			sum_q     <= '0;
			thresh_q  <= '0;
			floor_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_WINDOW_THRESHOLD) thresh_q <= cfg_data[TOTAL_W-1:0];
				if (cfg_index == CFG_DEFICIT_FLOOR) floor_q <= cfg_data;
			end
			if (state_q == ST_OUT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_UPD;
				ST_UPD: begin
					sum_q  <= sum_next;
					head_q <= (head_q == HEAD_W'(WINDOW_DAYS - 1)) ? '0 : head_q + 1'b1;
					if (!full) days_q <= days_q + 1'b1;
					state_q <= ST_MEAN;
				end
				ST_MEAN: if (mrsp.done) state_q <= ST_DEW;
				ST_DEW:  if (mrsp.done) state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {def_o_q, dew_o_q, mean_o_q, total_o_q};
	assign m_tuser  = flag_o_q;

	a_one_day: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("input taken while a day is in work");

	a_days_range: assert property (@(posedge clk) disable iff (!arst_n)
		days_q <= DAYS_W'(WINDOW_DAYS))
		else $error("day count beyond window");

	a_term_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_OUT) |-> !mrsp.busy)
		else $error("Magnus unit busy outside its phases");

endmodule

// ===== rtl/dtw_magnus.sv =====
module dtw_magnus (
	input  logic               clk,
	input  logic               arst_n,
	input  dtw_pkg::mag_req_t  req,
	output dtw_pkg::mag_rsp_t  rsp
);
	import dtw_pkg::*;

	typedef enum logic [9:0] {
		M_IDLE = 10'b0000000001,
		M_DIV  = 10'b0000000010,
		M_YQ   = 10'b0000000100,
		M_U    = 10'b0000001000,
		M_UL   = 10'b0000010000,
		M_HT   = 10'b0000100000,
		M_HQ   = 10'b0001000000,
		M_TA   = 10'b0010000000,
		M_E    = 10'b0100000000,
		M_FIN  = 10'b1000000000
	} mstate_t;

	localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

	mstate_t state_q;
	logic [37:0] dvd_q;
	logic [20:0] rem_q;
	logic [19:0] den_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic signed [17:0] ip_q;
	logic [29:0] u_q;
	logic [31:0] t_q;
	logic [2:0]  k_q;
	logic signed [65:0] prod_q;

	logic signed [24:0] num;
	logic [21:0] mag;
	logic [20:0] rem_sh;
	logic        fits;
	logic [37:0] quo_adj;
	logic signed [32:0] xq;
	logic signed [32:0] mul_a, mul_b;
	logic [63:0] quot_sh;
	logic [31:0] t_next;
	logic signed [18:0] shift_e;
	logic [TERM_W-1:0] term;
	recip_t rc;

	assign num = 25'sd150 * $signed({10'd0, req.kelvin}) - 25'sd2622240;
	assign mag = num[24] ? 22'(-num) : 22'(num);
	assign rem_sh = {rem_q[19:0], dvd_q[37]};
	assign fits = rem_sh >= {1'b0, den_q};
	assign quo_adj = dvd_q + {37'd0, (rem_q != '0)};
	assign xq = neg_q ? -$signed(quo_adj[32:0]) : $signed(dvd_q[32:0]);
	assign rc = recip(k_q);
	assign quot_sh = prod_q[63:0] >> rc.sh;
	assign t_next = ONE_Q30 + quot_sh[31:0];
	assign shift_e = 19'sd22 - 19'(ip_q);

	always_comb begin
		if (shift_e <= 19'sd0) begin
			term = TERM_W'({DEFICIT_MAX, 8'd0});
		end else if (shift_e >= 19'sd64) begin
			term = '0;
		end else begin
			term = prod_q[44:0] >> shift_e[5:0];
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			M_YQ: begin
				mul_a = xq;
				mul_b = 33'sd217706;
			end
			M_U: begin
				mul_a = $signed({17'd0, prod_q[31:16]});
				mul_b = 33'sd744261118;
			end
			M_HT: begin
				mul_a = $signed({3'd0, u_q});
				mul_b = $signed({1'b0, t_q});
			end
			M_HQ: begin
				mul_a = $signed({1'b0, prod_q[61:30]});
				mul_b = rc.mul;
			end
			M_E: begin
				mul_a = 33'sd9776;
				mul_b = $signed({1'b0, t_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			M_IDLE: begin
				dvd_q <= {mag, 16'd0};
				rem_q <= '0;
				den_q <= 20'(20 * 32'(req.kelvin) + 192);
				neg_q <= num[24];
			end
			M_DIV: begin
				dvd_q <= {dvd_q[36:0], fits};
				rem_q <= fits ? rem_sh - {1'b0, den_q} : rem_sh;
			end
			M_U: ip_q <= prod_q[49:32];
			M_UL: begin
				u_q <= prod_q[45:16];
				t_q <= ONE_Q30;
				k_q <= 3'd6;
			end
			M_TA: begin
				t_q <= t_next;
				k_q <= k_q - 3'd1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				M_IDLE: begin
					cnt_q <= 6'd37;
					if (req.start) state_q <= M_DIV;
				end
				M_DIV: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == '0) state_q <= M_YQ;
				end
				M_YQ: state_q <= M_U;
				M_U:  state_q <= M_UL;
				M_UL: state_q <= M_HT;
				M_HT: state_q <= M_HQ;
				M_HQ: state_q <= M_TA;
				M_TA: state_q <= (k_q == 3'd1) ? M_E : M_HT;
				M_E:  state_q <= M_FIN;
				M_FIN: state_q <= M_IDLE;
				default: state_q <= M_IDLE;
			endcase
		end
	end

	assign rsp.busy = state_q != M_IDLE;
	assign rsp.done = state_q == M_FIN;
	assign rsp.term = term;

endmodule
